>>> rtl/rtud_pkg.sv
// Shared types, constants and small functions for the random-to-decimal UID block.
// No dependencies; used by rtud_cell and random_to_decimal_uid.
package rtud_pkg;

  localparam int NDIG          = 39;  // decimal digits of a 128-bit value
  localparam int VAL_W         = 128;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VAL_W / BITS_PER_STEP;

  localparam logic [5:0] CHAR_ZERO = 6'd48;
  localparam logic [5:0] CHAR_DOT  = 6'd46;
  localparam logic [5:0] CHAR_TWO  = 6'd50;
  localparam logic [5:0] CHAR_FIVE = 6'd53;

  localparam logic [5:0] PREFIX_CAP     = 6'd62;
  localparam logic [5:0] LONG_FORM_LIM  = 6'd24;  // shorter prefixes use all 16 bytes
  localparam logic [4:0] BYTES_LONG     = 5'd16;
  localparam logic [4:0] BYTES_SHORT    = 5'd12;
  localparam logic [2:0] ROOT_LEN       = 3'd5;

  localparam logic [5:0] PAD_TABLE [16] = '{
    6'd3, 6'd5, 6'd8, 6'd10, 6'd13, 6'd15, 6'd17, 6'd20,
    6'd22, 6'd25, 6'd27, 6'd29, 6'd32, 6'd34, 6'd37, 6'd39
  };

  // register indexes on the config port
  localparam logic CFG_MODE       = 1'b0;
  localparam logic CFG_PREFIX_LEN = 1'b1;

  typedef struct packed {
    logic clear;  // zero the digit
    logic step;   // take BITS_PER_STEP bits of double-dabble
    logic shift;  // take the neighbor's digit
  } cell_ctrl_t;

  function automatic logic [3:0] add3(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? d + 4'd3 : d;
    return r;
  endfunction

  // characters of the "2.25." root
  function automatic logic [5:0] root_char(input logic [2:0] idx);
    logic [5:0] c;
    case (idx)
      3'd0: c = CHAR_TWO;
      3'd1: c = CHAR_DOT;
      3'd2: c = CHAR_TWO;
      3'd3: c = CHAR_FIVE;
      default: c = CHAR_DOT;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/random_to_decimal_uid.sv
// Top level: sequencer, value shifter and chain of 39 BCD cells that turn
// 128 random bits into UID suffix characters. Depends on rtud_pkg, rtud_cell.
//
// Input channel (in_valid/in_stall): one beat carries 128 random bits and a
//   type digit. in_stall is high while an item is being worked on.
// Output channel (out_valid/out_stall): one ASCII character per beat,
//   out_last high on the final character of the UID.
// Config port: cfg_wr_en/cfg_index/cfg_data; index 0 is mode, 1 is prefix
//   length. Write only while the block is idle.
// Timing: once an item is accepted, the cell chain converts 4 bits per cycle.
//   Then the chain's top cell is walked serially; each step emits its digit
//   as a character or skips a leading digit cell (up to 39 digit cells in
//   all). The next item is accepted as soon as the last character is in the
//   output register.
// Stall: a stalled character holds in the output register; the sequencer
//   waits, skips of leading zeros still proceed.
// Reset: synchronous, clears the sequencer, the output valid and both
//   config registers (mode 0, prefix length 0).
module random_to_decimal_uid import rtud_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_random_high,
  input  logic [63:0] in_random_low,
  input  logic [3:0]  in_type_digit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_character,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CONV  = 5'b00010,
    S_ROOT  = 5'b00100,
    S_TYPE  = 5'b01000,
    S_DIGIT = 5'b10000
  } state_t;

  localparam int CNT_W = $clog2(CONV_STEPS);

  state_t            state_r, state_nxt;
  logic              mode_r;
  logic [5:0]        plen_r;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              umode_r, umode_nxt;
  logic [3:0]        td_r, td_nxt;
  logic              padded_r, padded_nxt;
  logic [5:0]        target_r, target_nxt;
  logic [5:0]        pos_r, pos_nxt;
  logic [5:0]        rem_r, rem_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic              started_r, started_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [5:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  cell_ctrl_t        ctrl;
  logic [3:0]        bits_c  [NDIG-1];
  logic [3:0]        digit_c [NDIG];

  logic              accept;
  logic              out_free;
  logic [3:0]        top_digit;
  logic              skip;
  logic              digit_last;
  logic              td_valid;
  logic              long_form;
  logic [4:0]        nbytes;
  logic [63:0]       hi_forced;
  logic [63:0]       lo_forced;

  // ---- cell chain, cell 0 is the least significant digit ----
  genvar gi;
  generate
    for (gi = 0; gi < NDIG; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        rtud_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .in_bits  (val_r[VAL_W-1 -: BITS_PER_STEP]),
          .in_digit (4'd0),
          .out_bits (bits_c[gi]),
          .digit    (digit_c[gi])
        );
      end else if (gi == NDIG - 1) begin : g_top
        // a 128-bit value never carries out of the top digit
        rtud_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .in_bits  (bits_c[gi-1]),
          .in_digit (digit_c[gi-1]),
          .out_bits (),
          .digit    (digit_c[gi])
        );
      end else begin : g_mid
        rtud_cell u_cell (
          .clk      (clk),
          .ctrl     (ctrl),
          .in_bits  (bits_c[gi-1]),
          .in_digit (digit_c[gi-1]),
          .out_bits (bits_c[gi]),
          .digit    (digit_c[gi])
        );
      end
    end
  endgenerate

  // ---- handshake and decode ----
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign top_digit = digit_c[NDIG-1];

  assign td_valid  = (in_type_digit >= 4'd1) && (in_type_digit <= 4'd9);
  assign long_form = (plen_r < LONG_FORM_LIM);
  assign nbytes    = long_form ? BYTES_LONG : BYTES_SHORT;

  // version 4, variant 10
  assign hi_forced = {in_random_high[63:16], 4'h4, in_random_high[11:0]};
  assign lo_forced = {2'b10, in_random_low[61:0]};

  // padded form drops the always-zero cells above the table length;
  // minimal form drops leading zeros but keeps at least one digit
  assign skip = padded_r ? (rem_r > target_r)
                         : (!started_r && (top_digit == 4'd0) && (rem_r > 6'd1));
  assign digit_last = (rem_r == 6'd1) || (umode_r && (pos_r == PREFIX_CAP));

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    umode_nxt     = umode_r;
    td_nxt        = td_r;
    padded_nxt    = padded_r;
    target_nxt    = target_r;
    pos_nxt       = pos_r;
    rem_nxt       = rem_r;
    idx_nxt       = idx_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!mode_r) begin
            val_nxt = {hi_forced, lo_forced};
          end else if (long_form) begin
            val_nxt = {in_random_high, in_random_low};
          end else begin
            val_nxt = {32'd0, in_random_high, in_random_low[63:32]};
          end
          ctrl.clear = 1'b1;
          cnt_nxt    = '0;
          umode_nxt  = mode_r;
          td_nxt     = in_type_digit;
          padded_nxt = mode_r && td_valid;
          target_nxt = PAD_TABLE[4'(nbytes - 5'd1)];
          pos_nxt    = (plen_r > PREFIX_CAP) ? PREFIX_CAP : plen_r;
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.step = 1'b1;
        val_nxt   = val_r << BITS_PER_STEP;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CONV_STEPS - 1)) begin
          rem_nxt     = 6'(NDIG);
          started_nxt = 1'b0;
          idx_nxt     = 3'd0;
          if (!umode_r) begin
            state_nxt = S_ROOT;
          end else if (padded_r) begin
            state_nxt = S_TYPE;
          end else begin
            state_nxt = S_DIGIT;
          end
        end
      end
      S_ROOT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = root_char(idx_r);
          out_last_nxt  = 1'b0;
          idx_nxt       = idx_r + 3'd1;
          if (idx_r == ROOT_LEN - 3'd1) begin
            state_nxt = S_DIGIT;
          end
        end
      end
      S_TYPE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {2'b00, td_r};
          out_last_nxt  = (pos_r == PREFIX_CAP);
          pos_nxt       = pos_r + 6'd1;
          state_nxt     = (pos_r == PREFIX_CAP) ? S_IDLE : S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (skip) begin
          ctrl.shift = 1'b1;
          rem_nxt    = rem_r - 6'd1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {2'b00, top_digit};
          out_last_nxt  = digit_last;
          ctrl.shift    = 1'b1;
          rem_nxt       = rem_r - 6'd1;
          pos_nxt       = pos_r + 6'd1;
          started_nxt   = 1'b1;
          if (digit_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= 1'b0;
      plen_r      <= 6'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_MODE:       mode_r <= cfg_data[0];
          CFG_PREFIX_LEN: plen_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    cnt_r      <= cnt_nxt;
    umode_r    <= umode_nxt;
    td_r       <= td_nxt;
    padded_r   <= padded_nxt;
    target_r   <= target_nxt;
    pos_r      <= pos_nxt;
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    started_r  <= started_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

>>> rtl/rtud_cell.sv
// One BCD digit cell of the binary-to-decimal chain.
// Depends on rtud_pkg (add3, cell_ctrl_t, BITS_PER_STEP).
module rtud_cell import rtud_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic [3:0] in_bits,   // from the lower cell, first bit in [3]
  input  logic [3:0] in_digit,  // lower cell's digit, for the output shift
  output logic [3:0] out_bits,  // to the upper cell
  output logic [3:0] digit
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] d;

  // add-3 then shift, one bit at a time, MSB first
  always_comb begin
    d = digit_r;
    out_bits = '0;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      d = add3(d);
      out_bits[BITS_PER_STEP-1-s] = d[3];
      d = {d[2:0], in_bits[BITS_PER_STEP-1-s]};
    end
  end

  always_comb begin
    if (ctrl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctrl.step) begin
      digit_nxt = d;
    end else if (ctrl.shift) begin
      digit_nxt = in_digit;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit = digit_r;

endmodule
